// ===== design/rsds_pkg.sv =====
// Package for the raw string delimiter scanner.
// Holds the item types, the status codes, the character codes and the hash limit.
// No dependencies.
package rsds_pkg;

  localparam int unsigned MaxHashes = 255;
  localparam int unsigned CountW    = 8;

  localparam logic [7:0] ChR     = 8'h72;
  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;

  typedef enum logic [1:0] {
    StScan   = 2'd0,
    StAccept = 2'd1,
    StReject = 2'd2,
    StIdle   = 2'd3
  } status_e;

  typedef struct packed {
    logic       start_req;
    logic       raw_allowed;
    logic [7:0] char_code;
    logic       at_eof;
  } in_item_t;

  typedef struct packed {
    status_e           status;
    logic [CountW-1:0] hash_count;
  } out_item_t;

endpackage

// ===== design/raw_string_delimiter_scanner.sv =====
// Raw string delimiter scanner: one character per item, one status per item.
// Input register, scanner state update, result register.
// Depends on rsds_pkg.
//
//   channel | valid       | stall       | payload
//   input   | in_valid_i  | in_stall_o  | in_i  (rsds_pkg::in_item_t)
//   output  | out_valid_o | out_stall_i | out_o (rsds_pkg::out_item_t)
//
// One item per cycle unless the output stalls. The scanner state and
// the result register update together in the cycle the captured item
// moves on. Reset puts the scanner in idle with both counts zero and
// empties both registers. A stall on the output holds the result and,
// once the input register is full, stalls the input.
module raw_string_delimiter_scanner (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rsds_pkg::in_item_t  in_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rsds_pkg::out_item_t out_o
);
  import rsds_pkg::*;

  typedef enum logic [2:0] {
    PhIdle   = 3'd0,
    PhPrefix = 3'd1,
    PhOpen   = 3'd2,
    PhBody   = 3'd3,
    PhClose  = 3'd4
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [CountW-1:0] open_q, open_d;
  logic [CountW-1:0] close_q, close_d;
  logic              in_vld_q;
  in_item_t          in_q;
  logic              out_vld_q;
  out_item_t         out_q, out_d;
  logic              advance;
  logic              in_take;

  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;

  always_comb begin
    phase_e    ph;
    status_e   st;
    logic      is_ws;
    logic      done;
    ph       = phase_q;
    open_d   = open_q;
    close_d  = close_q;
    st       = StScan;
    done     = 1'b0;
    is_ws    = (in_q.char_code == ChSpace) || (in_q.char_code == ChTab) ||
               (in_q.char_code == ChLf) || (in_q.char_code == ChCr);
    out_d    = '{status: StIdle, hash_count: '0};
    if (in_q.start_req) begin
      open_d  = '0;
      close_d = '0;
      ph      = PhPrefix;
    end
    if (in_q.start_req && !in_q.raw_allowed) begin
      ph   = PhIdle;
      st   = StReject;
      done = 1'b1;
      out_d = '{status: StReject, hash_count: '0};
    end else begin
      unique case (ph)
        PhPrefix, PhOpen, PhBody, PhClose: begin
          if (in_q.at_eof) begin
            st = StReject;
            ph = PhIdle;
          end else begin
            unique case (ph)
              PhPrefix: begin
                if (in_q.char_code == ChR) begin
                  ph = PhOpen;
                end else if (!is_ws) begin
                  st = StReject;
                  ph = PhIdle;
                end
              end
              PhOpen: begin
                if (in_q.char_code == ChHash) begin
                  if (open_d >= CountW'(MaxHashes)) begin
                    st = StReject;
                    ph = PhIdle;
                  end else begin
                    open_d = open_d + 1'b1;
                  end
                end else if (in_q.char_code == ChQuote) begin
                  ph = PhBody;
                end else begin
                  st = StReject;
                  ph = PhIdle;
                end
              end
              default: begin
                if (ph == PhClose && in_q.char_code == ChHash) begin
                  close_d = close_d + 1'b1;
                  if (close_d == open_d) begin
                    st = StAccept;
                    ph = PhIdle;
                  end
                end else if (in_q.char_code == ChQuote) begin
                  if (open_d == '0) begin
                    st = StAccept;
                    ph = PhIdle;
                  end else begin
                    ph      = PhClose;
                    close_d = '0;
                  end
                end else begin
                  ph = PhBody;
                end
              end
            endcase
          end
          out_d = '{status: st, hash_count: open_d};
        end
        default: begin
          ph    = PhIdle;
          out_d = '{status: StIdle, hash_count: '0};
        end
      endcase
    end
    phase_d = (done) ? PhIdle : ph;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhIdle;
      open_q    <= '0;
      close_q   <= '0;
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        phase_q   <= phase_d;
        open_q    <= open_d;
        close_q   <= close_d;
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_i;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

endmodule

// ===== design/rsds_checker.sv =====
// Port-level checks for the raw string delimiter scanner.
// Bound to raw_string_delimiter_scanner; depends on rsds_pkg.
module rsds_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input rsds_pkg::out_item_t out_o
);
  import rsds_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_o))
    else $error("stalled output item changed");

  a_no_stall_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while output register empty");

  a_idle_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.status == StIdle |-> out_o.hash_count == '0)
    else $error("idle item carries a hash count");

  a_out_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o ##1 1'b1 |=> out_valid_o)
    else $error("accepted item did not reach the output");

endmodule

bind raw_string_delimiter_scanner rsds_checker u_rsds_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_o       (out_o)
);

// ===== tb/raw_string_delimiter_scanner_checker.sv =====
// Checker for the raw string delimiter scanner: watches both channels, predicts
// the status and hash count of every accepted item and checks them at the output.
// Depends on rsds_pkg.
`timescale 1ns / 1ps

module raw_string_delimiter_scanner_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  rsds_pkg::in_item_t  in_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  rsds_pkg::out_item_t out_i,
  output int unsigned         fail_count_o,
  output int unsigned         due_count_o
);
  import rsds_pkg::*;

  typedef enum logic [2:0] {
    PhIdle   = 3'd0,
    PhPrefix = 3'd1,
    PhOpen   = 3'd2,
    PhBody   = 3'd3,
    PhClose  = 3'd4
  } scan_phase_e;

  scan_phase_e       phase;
  logic [CountW-1:0] open_cnt;
  logic [CountW-1:0] close_cnt;
  out_item_t         status_due_q[$];
  int unsigned       fails;

  function automatic status_e content_char(logic [7:0] ch);
    if (ch == ChQuote) begin
      if (open_cnt == 0) begin
        phase = PhIdle;
        return StAccept;
      end
      phase     = PhClose;
      close_cnt = '0;
    end else begin
      phase = PhBody;
    end
    return StScan;
  endfunction

  function automatic out_item_t scan_step(in_item_t it);
    out_item_t res;
    status_e   st;
    res = '0;
    if (it.start_req) begin
      open_cnt  = '0;
      close_cnt = '0;
      if (!it.raw_allowed) begin
        phase      = PhIdle;
        res.status = StReject;
        return res;
      end
      phase = PhPrefix;
    end
    if (phase == PhIdle) begin
      res.status = StIdle;
      return res;
    end
    st = StScan;
    if (it.at_eof) begin
      st    = StReject;
      phase = PhIdle;
    end else begin
      case (phase)
        PhPrefix: begin
          if (it.char_code == ChR) begin
            phase = PhOpen;
          end else if (!(it.char_code inside {ChSpace, ChTab, ChLf, ChCr})) begin
            st    = StReject;
            phase = PhIdle;
          end
        end
        PhOpen: begin
          if (it.char_code == ChHash) begin
            if (open_cnt >= MaxHashes) begin
              st    = StReject;
              phase = PhIdle;
            end else begin
              open_cnt = open_cnt + 1'b1;
            end
          end else if (it.char_code == ChQuote) begin
            phase = PhBody;
          end else begin
            st    = StReject;
            phase = PhIdle;
          end
        end
        PhBody: begin
          st = content_char(it.char_code);
        end
        default: begin
          if (it.char_code == ChHash) begin
            close_cnt = close_cnt + 1'b1;
            if (close_cnt == open_cnt) begin
              st    = StAccept;
              phase = PhIdle;
            end
          end else begin
            st = content_char(it.char_code);
          end
        end
      endcase
    end
    res.status     = st;
    res.hash_count = open_cnt;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      phase     = PhIdle;
      open_cnt  = '0;
      close_cnt = '0;
      fails     = 0;
      status_due_q.delete();
      fail_count_o <= 0;
      due_count_o  <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        status_due_q.push_back(scan_step(in_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (status_due_q.size() == 0) begin
          $display("%0t: unexpected item: status %0d hash_count %0d", $time,
                   out_i.status, out_i.hash_count);
          fails++;
        end else begin
          want = status_due_q.pop_front();
          if (out_i.status !== want.status) begin
            $display("%0t: status mismatch: expected %0d actual %0d", $time,
                     want.status, out_i.status);
            fails++;
          end
          if (out_i.hash_count !== want.hash_count) begin
            $display("%0t: hash_count mismatch: expected %0d actual %0d", $time,
                     want.hash_count, out_i.hash_count);
            fails++;
          end
        end
      end
      due_count_o  <= status_due_q.size();
      fail_count_o <= fails;
    end
  end

endmodule

// ===== tb/raw_string_delimiter_scanner_test.sv =====
// Top of the raw string delimiter scanner testbench: clock, reset, character
// stimulus, output stalls, watchdog and verdict.
// Depends on rsds_pkg, raw_string_delimiter_scanner and its checker.
`timescale 1ns / 1ps

module raw_string_delimiter_scanner_test;
  import rsds_pkg::*;

  localparam int unsigned ItemTarget = 1850;
  localparam int unsigned StuckLimit = 1000;

  typedef enum int {
    FlawNone,
    FlawEof,
    FlawBadChar,
    FlawCut,
    FlawDenied
  } flaw_e;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  int unsigned fail_count;
  int unsigned due_count;
  int unsigned stuck;
  int unsigned sent;
  bit          tx_quiet;
  bit          rx_quiet;

  raw_string_delimiter_scanner u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_i       (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_o      (out_data)
  );

  raw_string_delimiter_scanner_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_i        (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_i       (out_data),
    .fail_count_o(fail_count),
    .due_count_o (due_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic in_item_t make_item(bit start, bit allowed, logic [7:0] ch, bit eof);
    in_item_t it;
    it.start_req   = start;
    it.raw_allowed = allowed;
    it.char_code   = ch;
    it.at_eof      = eof;
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    int unsigned gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic send_seq(input in_item_t seq[$]);
    foreach (seq[i]) send_item(seq[i]);
  endtask

  task automatic send_text(input string s);
    in_item_t seq[$];
    for (int i = 0; i < s.len(); i++) begin
      seq.push_back(make_item(i == 0, 1'b1, s[i], 1'b0));
    end
    send_seq(seq);
  endtask

  task automatic drive_literal(input int hashes);
    logic [7:0]  text[$];
    in_item_t    seq[$];
    int unsigned prefix_end;
    int unsigned body_len;
    int unsigned partial;
    int unsigned pos;
    int unsigned pick;
    flaw_e       flaw;
    logic [7:0]  ch;
    repeat ($urandom_range(0, 1) * $urandom_range(0, 3)) begin
      case ($urandom_range(0, 3))
        0:       text.push_back(ChSpace);
        1:       text.push_back(ChTab);
        2:       text.push_back(ChLf);
        default: text.push_back(ChCr);
      endcase
    end
    text.push_back(ChR);
    repeat (hashes) text.push_back(ChHash);
    text.push_back(ChQuote);
    prefix_end = text.size();
    body_len   = (hashes > 20) ? $urandom_range(0, 3) : $urandom_range(0, 10);
    repeat (body_len) begin
      if ($urandom_range(0, 9) < 7 || hashes == 0) begin
        ch = 8'($urandom_range(0, 255));
        if (ch == ChQuote) ch = ChR;
        text.push_back(ch);
      end else begin
        // quote followed by too few hashes stays content
        partial = (hashes > 8) ? hashes - 1 : $urandom_range(0, hashes - 1);
        text.push_back(ChQuote);
        repeat (partial) text.push_back(ChHash);
      end
    end
    text.push_back(ChQuote);
    repeat (hashes) text.push_back(ChHash);

    foreach (text[i]) begin
      seq.push_back(make_item(i == 0, (i == 0) ? 1'b1 : 1'($urandom_range(0, 1)),
                              text[i], 1'b0));
    end

    pick = $urandom_range(0, 99);
    if (pick < 70)      flaw = FlawNone;
    else if (pick < 80) flaw = FlawEof;
    else if (pick < 88) flaw = FlawBadChar;
    else if (pick < 95) flaw = FlawCut;
    else                flaw = FlawDenied;

    case (flaw)
      FlawEof: begin
        pos = $urandom_range(0, seq.size() - 1);
        seq[pos].at_eof    = 1'b1;
        seq[pos].char_code = 8'($urandom_range(0, 255));
        while (seq.size() > pos + 1) void'(seq.pop_back());
      end
      FlawBadChar: begin
        pos = $urandom_range(0, prefix_end - 1);
        seq[pos].char_code = 8'($urandom_range(0, 255));
      end
      FlawCut: begin
        pos = $urandom_range(1, seq.size() - 1);
        while (seq.size() > pos) void'(seq.pop_back());
      end
      FlawDenied: begin
        seq[0].raw_allowed = 1'b0;
      end
      default: begin
      end
    endcase
    send_seq(seq);
  endtask

  initial begin
    int unsigned seq_no;
    int          hashes;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    tx_quiet = 1'b0;
    sent     = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(make_item(1'b0, 1'b1, 8'hFF, 1'b0));
    send_item(make_item(1'b1, 1'b0, ChR, 1'b0));
    send_item(make_item(1'b1, 1'b1, ChR, 1'b1));
    send_text("x");
    send_text(" \t\n\rr\"\"");
    send_text("r##\"\"#\"##");
    send_text("r#x");

    seq_no = 0;
    while (sent < ItemTarget) begin
      tx_quiet = ($urandom_range(0, 4) == 0);
      if (seq_no == 5)                     hashes = MaxHashes;
      else if (seq_no == 11)               hashes = MaxHashes + 1;
      else if ($urandom_range(0, 7) == 0)  hashes = $urandom_range(5, 20);
      else                                 hashes = $urandom_range(0, 4);
      drive_literal(hashes);
      // idle noise between scans
      repeat ($urandom_range(0, 2)) begin
        send_item(make_item(1'b0, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                            1'($urandom_range(0, 1))));
      end
      seq_no++;
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (due_count != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("raw_string_delimiter_scanner test passed");
    end else begin
      $display("raw_string_delimiter_scanner test failed");
    end
    $finish;
  end

  initial begin
    int unsigned hold;
    rx_quiet = 1'b0;
    forever begin
      if ($urandom_range(0, 39) == 0) rx_quiet = !rx_quiet;
      hold = rx_quiet ? 0 : $urandom_range(0, 17);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck <= 0;
    end else if (stuck >= StuckLimit) begin
      $display("raw_string_delimiter_scanner test failed");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

endmodule
